/* hw/rtl/otp_pkg.sv */
// Shared types and constants for the overlap tile padding address generator.
// Used by otp_cfg, otp_reflect_pipe, overlap_tile_padding_address_gen and the testbench.
`timescale 1ns / 1ps

package otp_pkg;

	// limits of the register ranges
	localparam int MAX_VOLUME_DIM = 4096;
	localparam int MAX_TILE_EDGE  = 1000;
	localparam int MAX_BORDER     = 500;
	localparam int MAX_SLICES     = 25;

	// widths
	localparam int DIM_W      = 13;  // dimension values up to MAX_VOLUME_DIM
	localparam int COORD_W    = 12;  // voxel coordinates
	localparam int SC_W       = 14;  // signed coordinate before bounds check
	localparam int EDGE_W     = 10;
	localparam int BORDER_W   = 9;
	localparam int SLICE_W    = 5;
	localparam int HALF_W     = 4;
	localparam int BEDGE_W    = 11;  // bordered edge
	localparam int BAREA_W    = 22;  // bordered edge squared
	localparam int IDX_W      = 27;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int MOD_STAGES = DIM_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VOL_W  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_H  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOL_D  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BORDER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SLICES = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIRROR = 3'd6;

	// config divider sequencer
	typedef enum logic [1:0] {
		CD_LOAD,
		CD_STEP,
		CD_IDLE
	} cd_state_t;

	// how the final stage forms one axis coordinate
	typedef enum logic [1:0] {
		AX_PASS,
		AX_NEG,
		AX_HIGH,
		AX_ZERO
	} ax_mode_t;

	// derived configuration seen by the datapath
	typedef struct packed {
		logic                busy;
		logic [DIM_W-1:0]    w;
		logic [DIM_W-1:0]    h;
		logic [DIM_W-1:0]    d;
		logic [BORDER_W-1:0] b;
		logic [HALF_W-1:0]   half;
		logic [BEDGE_W-1:0]  e;
		logic [BAREA_W-1:0]  ee;
		logic                mirror;
		logic [COORD_W-1:0]  last_x;
		logic [COORD_W-1:0]  last_y;
		logic [DIM_W-1:0]    step_x;
		logic [DIM_W-1:0]    step_y;
	} cfg_t;

	// side data carried alongside the modulo lanes
	typedef struct packed {
		logic               pad;
		logic [COORD_W-1:0] z;
		logic [IDX_W-1:0]   idx;
		ax_mode_t           x_mode;
		ax_mode_t           y_mode;
		logic [COORD_W-1:0] x_pass;
		logic [COORD_W-1:0] y_pass;
	} side_t;

endpackage

/* hw/rtl/otp_cfg.sv */
// Configuration registers, range clamps and the derived tile constants.
// A shared iterative divider computes tile counts and steps; depends on otp_pkg.
`timescale 1ns / 1ps

module otp_cfg import otp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [DIM_W-1:0]    vw_q, vh_q, vd_q;
	logic [EDGE_W-1:0]   te_q;
	logic [BORDER_W-1:0] bw_q;
	logic [SLICE_W-1:0]  sc_q;
	logic                mir_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vw_q  <= 13'd256;
			vh_q  <= 13'd256;
			vd_q  <= 13'd16;
			te_q  <= 10'd244;
			bw_q  <= 9'd92;
			sc_q  <= 5'd5;
			mir_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VOL_W:  vw_q  <= cfg_data;
				REG_VOL_H:  vh_q  <= cfg_data;
				REG_VOL_D:  vd_q  <= cfg_data;
				REG_TILE:   te_q  <= cfg_data[EDGE_W-1:0];
				REG_BORDER: bw_q  <= cfg_data[BORDER_W-1:0];
				REG_SLICES: sc_q  <= cfg_data[SLICE_W-1:0];
				REG_MIRROR: mir_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// saturate to the legal ranges
	logic [DIM_W-1:0]    w, h, d;
	logic [EDGE_W-1:0]   t;
	logic [BORDER_W-1:0] b;
	logic [SLICE_W-1:0]  s;
	logic [BEDGE_W-1:0]  e;
	logic [COORD_W-1:0]  last_x, last_y;

	always_comb begin
		w = (vw_q == '0) ? DIM_W'(1) : (vw_q > DIM_W'(MAX_VOLUME_DIM)) ? DIM_W'(MAX_VOLUME_DIM) : vw_q;
		h = (vh_q == '0) ? DIM_W'(1) : (vh_q > DIM_W'(MAX_VOLUME_DIM)) ? DIM_W'(MAX_VOLUME_DIM) : vh_q;
		d = (vd_q == '0) ? DIM_W'(1) : (vd_q > DIM_W'(MAX_VOLUME_DIM)) ? DIM_W'(MAX_VOLUME_DIM) : vd_q;
		t = (te_q == '0) ? EDGE_W'(1) : (te_q > EDGE_W'(MAX_TILE_EDGE)) ? EDGE_W'(MAX_TILE_EDGE) : te_q;
		b = (bw_q > BORDER_W'(MAX_BORDER)) ? BORDER_W'(MAX_BORDER) : bw_q;
		s = (sc_q == '0) ? SLICE_W'(1) : (sc_q > SLICE_W'(MAX_SLICES)) ? SLICE_W'(MAX_SLICES) : sc_q;
		e = BEDGE_W'(t) + {1'b0, b, 1'b0};
		// last tile start, zero when the volume is smaller than the tile
		last_x = (w > DIM_W'(t)) ? COORD_W'(w - DIM_W'(t)) : '0;
		last_y = (h > DIM_W'(t)) ? COORD_W'(h - DIM_W'(t)) : '0;
	end

	logic [BAREA_W-1:0] ee_q;
	always_ff @(posedge clk) begin
		ee_q <= BAREA_W'(e) * BAREA_W'(e);
	end

	// divider sequencer: tiles_x, step_x, tiles_y, step_y
	cd_state_t        state_q, state_n;
	logic [1:0]       op_q;
	logic [3:0]       cnt_q;
	logic [DIM_W-1:0] dvd_q, dvs_q, rem_q, quo_q;
	logic [DIM_W-1:0] tiles_x_q, step_x_q, tiles_y_q, step_y_q;
	logic [DIM_W-1:0] ld_dvd, ld_dvs;
	logic [DIM_W:0]   trial;
	logic             ge;
	logic             last_bit;

	always_comb begin
		case (op_q)
			2'd0: begin
				ld_dvd = w + DIM_W'(t) - DIM_W'(1);
				ld_dvs = DIM_W'(t);
			end
			2'd1: begin
				ld_dvd = DIM_W'(last_x) + tiles_x_q;
				ld_dvs = tiles_x_q;
			end
			2'd2: begin
				ld_dvd = h + DIM_W'(t) - DIM_W'(1);
				ld_dvs = DIM_W'(t);
			end
			default: begin
				ld_dvd = DIM_W'(last_y) + tiles_y_q;
				ld_dvs = tiles_y_q;
			end
		endcase
		trial    = {rem_q, dvd_q[DIM_W-1]};
		ge       = (trial >= {1'b0, dvs_q});
		last_bit = (cnt_q == 4'(DIM_W - 1));
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			CD_LOAD: state_n = CD_STEP;
			CD_STEP: begin
				if (last_bit) state_n = (op_q == 2'd3) ? CD_IDLE : CD_LOAD;
			end
			CD_IDLE: state_n = CD_IDLE;
			default: state_n = CD_IDLE;
		endcase
		if (cfg_we) state_n = CD_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CD_LOAD;
			op_q    <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				op_q <= '0;
			end else if (state_q == CD_STEP && last_bit) begin
				op_q <= op_q + 2'd1;
			end
			cnt_q <= (state_q == CD_STEP) ? cnt_q + 4'd1 : '0;
		end
	end

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == CD_LOAD) begin
			dvd_q <= ld_dvd;
			dvs_q <= ld_dvs;
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == CD_STEP) begin
			dvd_q <= {dvd_q[DIM_W-2:0], 1'b0};
			rem_q <= ge ? DIM_W'(trial - {1'b0, dvs_q}) : trial[DIM_W-1:0];
			quo_q <= {quo_q[DIM_W-2:0], ge};
			if (last_bit) begin
				case (op_q)
					2'd0:    tiles_x_q <= {quo_q[DIM_W-2:0], ge};
					2'd1:    step_x_q  <= {quo_q[DIM_W-2:0], ge};
					2'd2:    tiles_y_q <= {quo_q[DIM_W-2:0], ge};
					default: step_y_q  <= {quo_q[DIM_W-2:0], ge};
				endcase
			end
		end
	end

	assign cfg.busy   = (state_q != CD_IDLE);
	assign cfg.w      = w;
	assign cfg.h      = h;
	assign cfg.d      = d;
	assign cfg.b      = b;
	assign cfg.half   = s[SLICE_W-1:1];
	assign cfg.e      = e;
	assign cfg.ee     = ee_q;
	assign cfg.mirror = mir_q;
	assign cfg.last_x = last_x;
	assign cfg.last_y = last_y;
	assign cfg.step_x = step_x_q;
	assign cfg.step_y = step_y_q;

endmodule

/* hw/rtl/otp_reflect_pipe.sv */
// Pipelined remainder for the x and y reflections, one bit per stage.
// Side data rides along; stages collapse bubbles under stall. Depends on otp_pkg.
`timescale 1ns / 1ps

module otp_reflect_pipe import otp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [DIM_W-1:0] in_ax,
	input  logic [DIM_W-1:0] in_mx,
	input  logic [DIM_W-1:0] in_ay,
	input  logic [DIM_W-1:0] in_my,
	input  side_t            in_side,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [DIM_W-1:0] out_rx,
	output logic [DIM_W-1:0] out_ry,
	output side_t            out_side
);

	logic [DIM_W-1:0]      ax_s [MOD_STAGES];
	logic [DIM_W-1:0]      mx_s [MOD_STAGES];
	logic [DIM_W-1:0]      rx_s [MOD_STAGES];
	logic [DIM_W-1:0]      ay_s [MOD_STAGES];
	logic [DIM_W-1:0]      my_s [MOD_STAGES];
	logic [DIM_W-1:0]      ry_s [MOD_STAGES];
	side_t                 sd_s [MOD_STAGES];
	logic [MOD_STAGES-1:0] v_s;
	logic [MOD_STAGES:0]   en;

	// a stage loads when it is empty or its successor moves
	assign en[MOD_STAGES] = !out_stall;
	genvar k;
	generate
		for (k = 0; k < MOD_STAGES; k++) begin : g_en
			assign en[k] = !v_s[k] || en[k+1];
		end

		for (k = 0; k < MOD_STAGES; k++) begin : g_stage
			logic [DIM_W-1:0] p_ax, p_mx, p_rx, p_ay, p_my, p_ry;
			side_t            p_sd;
			logic             p_v;
			logic [DIM_W:0]   tx, ty;

			if (k == 0) begin : g_first
				assign p_ax = in_ax;
				assign p_mx = in_mx;
				assign p_rx = '0;
				assign p_ay = in_ay;
				assign p_my = in_my;
				assign p_ry = '0;
				assign p_sd = in_side;
				assign p_v  = in_valid;
			end else begin : g_next
				assign p_ax = ax_s[k-1];
				assign p_mx = mx_s[k-1];
				assign p_rx = rx_s[k-1];
				assign p_ay = ay_s[k-1];
				assign p_my = my_s[k-1];
				assign p_ry = ry_s[k-1];
				assign p_sd = sd_s[k-1];
				assign p_v  = v_s[k-1];
			end

			// bring in the next dividend bit, subtract if it fits
			assign tx = {p_rx, p_ax[DIM_W-1]};
			assign ty = {p_ry, p_ay[DIM_W-1]};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else if (en[k]) begin
					v_s[k] <= p_v;
				end
			end

			always_ff @(posedge clk) begin
				if (en[k]) begin
					ax_s[k] <= {p_ax[DIM_W-2:0], 1'b0};
					ay_s[k] <= {p_ay[DIM_W-2:0], 1'b0};
					mx_s[k] <= p_mx;
					my_s[k] <= p_my;
					rx_s[k] <= (tx >= {1'b0, p_mx}) ? DIM_W'(tx - {1'b0, p_mx}) : tx[DIM_W-1:0];
					ry_s[k] <= (ty >= {1'b0, p_my}) ? DIM_W'(ty - {1'b0, p_my}) : ty[DIM_W-1:0];
					sd_s[k] <= p_sd;
				end
			end
		end
	endgenerate

	assign in_stall  = !en[0];
	assign out_valid = v_s[MOD_STAGES-1];
	assign out_rx    = rx_s[MOD_STAGES-1];
	assign out_ry    = ry_s[MOD_STAGES-1];
	assign out_side  = sd_s[MOD_STAGES-1];

endmodule

/* hw/rtl/overlap_tile_padding_address_gen.sv */
// Overlap tile padding address generator, top level.
// Instantiates otp_cfg and otp_reflect_pipe; depends on otp_pkg.
`timescale 1ns / 1ps

// One position of a bordered tile goes in per beat and one address beat comes out:
// the source voxel x/y/z, a zero-padding flag and the z-major buffer index. The
// block takes one beat per cycle unless the divider runs or the output stalls. Two
// setup stages, thirteen remainder stages for the mirror reflection and one output
// register form the pipe. After reset and every configuration write the input stalls
// while a shared bit-serial divider derives tile counts and steps (four divides).
module overlap_tile_padding_address_gen import otp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [9:0]            tile_col,
	input  logic [9:0]            tile_row,
	input  logic [11:0]           center_slice,
	input  logic [10:0]           pos_x,
	input  logic [10:0]           pos_y,
	input  logic [4:0]            pos_z,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [11:0]           src_x,
	output logic [11:0]           src_y,
	output logic [11:0]           src_z,
	output logic                  pad_zero,
	output logic [26:0]           buffer_index
);

	cfg_t cfg;

	otp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic en_s1, en_s2, en_o, rp_in_stall, rp_valid, accept;
	logic v_s1, v_s2, v_o;

	// stage enables, bubbles collapse
	assign en_o       = !v_o || !result_stall;
	assign en_s2      = !v_s2 || !rp_in_stall;
	assign en_s1      = !v_s1 || en_s2;
	assign item_stall = cfg.busy || !en_s1;
	assign accept     = item_valid && !item_stall;

	// stage 1: products and slice position
	logic [22:0]        sx_s1, sy_s1;
	logic [IDX_W-1:0]   mz_s1;
	logic [BAREA_W-1:0] my_s1;
	logic [10:0]        px_s1;
	logic [SC_W-1:0]    z_s1;
	logic               zpad_s1;
	logic signed [SC_W-1:0] z_c;

	assign z_c = $signed({2'b0, center_slice}) - $signed({10'b0, cfg.half})
		+ $signed({9'b0, pos_z});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sx_s1   <= 23'(tile_col) * 23'(cfg.step_x);
			sy_s1   <= 23'(tile_row) * 23'(cfg.step_y);
			mz_s1   <= IDX_W'(pos_z) * IDX_W'(cfg.ee);
			my_s1   <= BAREA_W'(pos_y) * BAREA_W'(cfg.e);
			px_s1   <= pos_x;
			z_s1    <= z_c;
			zpad_s1 <= z_c[SC_W-1] || (z_c >= $signed({1'b0, cfg.d}));
		end
	end

	// py needs to travel too for y coordinate
	logic [10:0] py_s1;
	always_ff @(posedge clk) begin
		if (en_s1) py_s1 <= pos_y;
	end

	// stage 2: clamp tile start, remove border, classify
	logic [COORD_W-1:0]     st_x, st_y;
	logic signed [SC_W-1:0] x_c, y_c;
	logic                   xneg, yneg, xhi, yhi, outside;
	logic [DIM_W-1:0]       ax_n, mx_n, ay_n, my_n;
	logic [SC_W-1:0]        xabs, yabs;
	side_t                  sd_n;

	always_comb begin
		st_x = (sx_s1 > 23'(cfg.last_x)) ? cfg.last_x : sx_s1[COORD_W-1:0];
		st_y = (sy_s1 > 23'(cfg.last_y)) ? cfg.last_y : sy_s1[COORD_W-1:0];
		x_c  = $signed({2'b0, st_x}) - $signed({5'b0, cfg.b}) + $signed({3'b0, px_s1});
		y_c  = $signed({2'b0, st_y}) - $signed({5'b0, cfg.b}) + $signed({3'b0, py_s1});
		xneg = x_c[SC_W-1];
		yneg = y_c[SC_W-1];
		xhi  = !xneg && (x_c >= $signed({1'b0, cfg.w}));
		yhi  = !yneg && (y_c >= $signed({1'b0, cfg.h}));
		outside = xneg || yneg || xhi || yhi;
		xabs = SC_W'(-x_c);
		yabs = SC_W'(-y_c);

		// remainder operands: |c| mod dim below zero, c mod (dim-1) above
		ax_n = xneg ? xabs[DIM_W-1:0] : x_c[DIM_W-1:0];
		mx_n = xneg ? cfg.w : cfg.w - DIM_W'(1);
		ay_n = yneg ? yabs[DIM_W-1:0] : y_c[DIM_W-1:0];
		my_n = yneg ? cfg.h : cfg.h - DIM_W'(1);

		sd_n.idx    = mz_s1 + IDX_W'(my_s1) + IDX_W'(px_s1);
		sd_n.pad    = 1'b0;
		sd_n.z      = z_s1[COORD_W-1:0];
		sd_n.x_mode = AX_PASS;
		sd_n.y_mode = AX_PASS;
		sd_n.x_pass = x_c[COORD_W-1:0];
		sd_n.y_pass = y_c[COORD_W-1:0];
		if (zpad_s1) begin
			// slice outside the volume: all zero, no z reflection
			sd_n.pad    = 1'b1;
			sd_n.z      = '0;
			sd_n.x_pass = '0;
			sd_n.y_pass = '0;
		end else if (outside && !cfg.mirror) begin
			sd_n.pad    = 1'b1;
			sd_n.x_pass = '0;
			sd_n.y_pass = '0;
		end else if (outside) begin
			if (xneg)                          sd_n.x_mode = AX_NEG;
			else if (xhi && cfg.w == DIM_W'(1)) sd_n.x_mode = AX_ZERO;
			else if (xhi)                      sd_n.x_mode = AX_HIGH;
			if (yneg)                          sd_n.y_mode = AX_NEG;
			else if (yhi && cfg.h == DIM_W'(1)) sd_n.y_mode = AX_ZERO;
			else if (yhi)                      sd_n.y_mode = AX_HIGH;
		end
	end

	logic [DIM_W-1:0] ax_s2, mx_s2, ay_s2, my_s2;
	side_t            sd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ax_s2 <= ax_n;
			mx_s2 <= mx_n;
			ay_s2 <= ay_n;
			my_s2 <= my_n;
			sd_s2 <= sd_n;
		end
	end

	// remainder lanes
	logic [DIM_W-1:0] rx, ry;
	side_t            sd_r;

	otp_reflect_pipe u_reflect (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_stall  (rp_in_stall),
		.in_ax     (ax_s2),
		.in_mx     (mx_s2),
		.in_ay     (ay_s2),
		.in_my     (my_s2),
		.in_side   (sd_s2),
		.out_valid (rp_valid),
		.out_stall (!en_o),
		.out_rx    (rx),
		.out_ry    (ry),
		.out_side  (sd_r)
	);

	// final coordinate per axis
	logic [COORD_W-1:0] fx, fy;
	logic [DIM_W-1:0]   hx, hy;

	always_comb begin
		hx = cfg.w - DIM_W'(1) - rx;
		hy = cfg.h - DIM_W'(1) - ry;
		case (sd_r.x_mode)
			AX_NEG:  fx = rx[COORD_W-1:0];
			AX_HIGH: fx = hx[COORD_W-1:0];
			AX_ZERO: fx = '0;
			default: fx = sd_r.x_pass;
		endcase
		case (sd_r.y_mode)
			AX_NEG:  fy = ry[COORD_W-1:0];
			AX_HIGH: fy = hy[COORD_W-1:0];
			AX_ZERO: fy = '0;
			default: fy = sd_r.y_pass;
		endcase
	end

	// output register
	logic [COORD_W-1:0] res_x_q, res_y_q, res_z_q;
	logic               res_pad_q;
	logic [IDX_W-1:0]   res_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en_o) begin
			v_o <= rp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o) begin
			res_x_q   <= fx;
			res_y_q   <= fy;
			res_z_q   <= sd_r.z;
			res_pad_q <= sd_r.pad;
			res_idx_q <= sd_r.idx;
		end
	end

	assign result_valid = v_o;
	assign src_x        = res_x_q;
	assign src_y        = res_y_q;
	assign src_z        = res_z_q;
	assign pad_zero     = res_pad_q;
	assign buffer_index = res_idx_q;

endmodule

/* tb/tb_overlap_tile_padding_address_gen.sv */
// Testbench for overlap_tile_padding_address_gen: random and directed tile positions,
// checked against an in-bench address predictor. Depends on otp_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_overlap_tile_padding_address_gen import otp_pkg::*;;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 24;
	localparam int TOTAL_ITEMS    = 1350;

	typedef struct {
		logic [11:0] sx;
		logic [11:0] sy;
		logic [11:0] sz;
		logic        pad;
		logic [26:0] bidx;
	} addr_t;

	// ordered store of predicted addresses
	class addr_scoreboard;
		addr_t pending[$];
		int    mismatches;
		int    matched;

		function void note(addr_t a);
			pending.push_back(a);
		endfunction

		function void check(addr_t got);
			addr_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected address beat x=%0d y=%0d z=%0d", got.sx, got.sy,
						got.sz);
				return;
			end
			want = pending.pop_front();
			if (got.sx !== want.sx || got.sy !== want.sy || got.sz !== want.sz ||
					got.pad !== want.pad || got.bidx !== want.bidx) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: exp x=%0d y=%0d z=%0d pad=%0b idx=%0d, %s",
						want.sx, want.sy, want.sz, want.pad, want.bidx,
						$sformatf("got x=%0d y=%0d z=%0d pad=%0b idx=%0d",
							got.sx, got.sy, got.sz, got.pad, got.bidx));
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic item_valid, item_stall;
	logic [9:0] tile_col, tile_row;
	logic [11:0] center_slice;
	logic [10:0] pos_x, pos_y;
	logic [4:0] pos_z;
	logic result_valid, result_stall;
	logic [11:0] src_x, src_y, src_z;
	logic pad_zero;
	logic [26:0] buffer_index;

	overlap_tile_padding_address_gen uut (.*);

	addr_scoreboard sb = new();

	// register copies as the block holds them
	logic [12:0] vol_w, vol_h, vol_d;
	logic [9:0]  edge_len;
	logic [8:0]  border;
	logic [4:0]  slices;
	logic        mirror;

	int sent, send_idle_pct, recv_idle_pct, idle_cycles, configs_run;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
	end

	function automatic longint sat(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint axis_start(longint dim, longint t, longint n);
		longint tiles, last, step;
		tiles = (dim + t - 1) / t;
		last  = dim > t ? dim - t : 0;
		step  = (last + tiles) / tiles;
		return n * step < last ? n * step : last;
	endfunction

	function automatic longint mirror_coord(longint c, longint dim);
		if (c < 0) c = (-c) % dim;
		if (c >= dim) c = (dim == 1) ? 0 : (dim - 1) - (c % (dim - 1));
		return c;
	endfunction

	function automatic addr_t predict_addr(longint col, longint row, longint cz, longint px,
			longint py, longint pz);
		longint w, h, d, t, b, s, e, x, y, z;
		addr_t a;
		w = sat(vol_w, 1, MAX_VOLUME_DIM);
		h = sat(vol_h, 1, MAX_VOLUME_DIM);
		d = sat(vol_d, 1, MAX_VOLUME_DIM);
		t = sat(edge_len, 1, MAX_TILE_EDGE);
		b = sat(border, 0, MAX_BORDER);
		s = sat(slices, 1, MAX_SLICES);
		e = t + 2 * b;
		x = axis_start(w, t, col) - b + px;
		y = axis_start(h, t, row) - b + py;
		z = cz - s / 2 + pz;
		a.pad = 0;
		if (z < 0 || z >= d) begin
			a.pad = 1;
			x = 0; y = 0; z = 0;
		end else if (x < 0 || x >= w || y < 0 || y >= h) begin
			if (mirror) begin
				x = mirror_coord(x, w);
				y = mirror_coord(y, h);
			end else begin
				a.pad = 1;
				x = 0; y = 0;
			end
		end
		a.sx = x[11:0];
		a.sy = y[11:0];
		a.sz = z[11:0];
		a.bidx = 27'(pz * e * e + py * e + px);
		return a;
	endfunction

	// one input beat with optional leading gap
	task automatic send_beat(logic [9:0] col, logic [9:0] row, logic [11:0] cz,
			logic [10:0] px, logic [10:0] py, logic [4:0] pz);
		addr_t a;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		a = predict_addr(col, row, cz, px, py, pz);
		item_valid   <= 1;
		tile_col     <= col;
		tile_row     <= row;
		center_slice <= cz;
		pos_x        <= px;
		pos_y        <= py;
		pos_z        <= pz;
		do @(posedge clk); while (item_stall);
		sb.note(a);
		sent++;
		// idle profile follows overall progress
		if (sent < TOTAL_ITEMS / 3) begin
			send_idle_pct = 34; recv_idle_pct = 51;
		end else if (sent < 2 * TOTAL_ITEMS / 3) begin
			send_idle_pct = 51; recv_idle_pct = 34;
		end else begin
			send_idle_pct = 0; recv_idle_pct = 0;
		end
	endtask

	task automatic drain();
		item_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// back-to-back register writes, block idle
	task automatic write_regs(int w, int h, int d, int t, int b, int s, int m);
		logic [CFG_IDX_W-1:0] regs[7];
		int vals[7];
		regs = '{REG_VOL_W, REG_VOL_H, REG_VOL_D, REG_TILE, REG_BORDER, REG_SLICES, REG_MIRROR};
		vals = '{w, h, d, t, b, s, m};
		for (int i = 0; i < 7; i++) begin
			cfg_we    <= 1;
			cfg_index <= regs[i];
			cfg_data  <= CFG_DATA_W'(vals[i]);
			@(posedge clk);
		end
		cfg_we <= 0;
		vol_w = 13'(w); vol_h = 13'(h); vol_d = 13'(d);
		edge_len = 10'(t); border = 9'(b); slices = 5'(s); mirror = 1'(m);
		configs_run++;
	endtask

	// random beat, mostly around the interesting part of the current tiling
	task automatic random_beat();
		int t, e, d, cmax;
		t = int'(sat(edge_len, 1, MAX_TILE_EDGE));
		e = t + 2 * int'(sat(border, 0, MAX_BORDER));
		d = int'(sat(vol_d, 1, MAX_VOLUME_DIM));
		cmax = int'(sat(sat(vol_w, 1, MAX_VOLUME_DIM) / t + 2, 0, 1023));
		if ($urandom_range(7) == 0)
			send_beat(10'($urandom), 10'($urandom), 12'($urandom), 11'($urandom),
				11'($urandom), 5'($urandom));
		else
			send_beat(10'($urandom_range(cmax, 0)), 10'($urandom_range(cmax, 0)),
				12'($urandom_range(sat(d + 3, 0, 4095), 0)),
				11'($urandom_range(sat(e + 2, 0, 2047), 0)),
				11'($urandom_range(sat(e + 2, 0, 2047), 0)),
				5'($urandom_range(sat(slices + 1, 0, 31), 0)));
	endtask

	// result side: stall pattern, checking, watchdog
	always @(posedge clk) begin
		addr_t got;
		if (arst_n && result_valid && !result_stall) begin
			got.sx = src_x; got.sy = src_y; got.sz = src_z;
			got.pad = pad_zero; got.bidx = buffer_index;
			sb.check(got);
		end
		if ((result_valid && !result_stall) || (item_valid && !item_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("** overlap_tile_padding_address_gen: FAILED **");
			$finish;
		end
		result_stall <= arst_n && ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		int n;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		item_valid = 0; tile_col = 0; tile_row = 0; center_slice = 0;
		pos_x = 0; pos_y = 0; pos_z = 0; result_stall = 0;
		sent = 0; idle_cycles = 0; configs_run = 0;
		send_idle_pct = 34; recv_idle_pct = 51;
		vol_w = 256; vol_h = 256; vol_d = 16; edge_len = 244; border = 92;
		slices = 5; mirror = 1;
		@(posedge arst_n);
		@(posedge clk);

		// directed: reset settings, field extremes, edges of the volume
		send_beat(0, 0, 0, 0, 0, 0);
		send_beat(1023, 1023, 4095, 2047, 2047, 31);
		send_beat(1, 0, 2, 92, 92, 2);
		send_beat(1, 1, 7, 427, 427, 4);
		send_beat(0, 0, 15, 0, 300, 2);
		send_beat(0, 1, 16, 50, 50, 3);
		send_beat(5, 5, 8, 1000, 1000, 0);
		send_beat(0, 0, 1, 91, 10, 0);
		send_beat(0, 0, 14, 348, 348, 4);
		send_beat(2, 3, 3, 1024, 1, 16);
		drain();
		// zero padding, small tiles
		write_regs(100, 37, 9, 16, 4, 3, 0);
		send_beat(0, 0, 0, 0, 0, 0);
		send_beat(7, 3, 8, 23, 23, 2);
		send_beat(6, 2, 4, 2, 3, 1);
		drain();
		// dimension of one reflects to zero
		write_regs(1, 1, 1, 4, 0, 1, 1);
		send_beat(0, 0, 0, 3, 2, 0);
		send_beat(3, 3, 0, 1, 1, 0);
		send_beat(0, 0, 1, 0, 0, 0);
		drain();
		// volume smaller than tile, even slice count
		write_regs(2, 2, 2, 3, 2, 4, 1);
		send_beat(0, 0, 0, 0, 6, 0);
		send_beat(1, 1, 1, 6, 0, 3);
		drain();

		// fixed extreme settings, then random ones
		for (int p = 0; sent < TOTAL_ITEMS; p++) begin
			case (p)
				0: write_regs(4096, 4096, 4096, 1000, 500, 25, 1);
				1: write_regs(0, 8191, 5000, 1023, 511, 31, 1);
				2: write_regs(200, 3, 30, 0, 0, 0, 0);
				3: write_regs(50, 300, 20, 7, 3, 4, 1);
				4: write_regs(8191, 0, 1, 4, 511, 1, 0);
				default: write_regs($urandom_range(300, 1), $urandom_range(300, 1),
					$urandom_range(40, 1), $urandom_range(64, 4), $urandom_range(20, 0),
					$urandom_range(25, 1), $urandom_range(1, 0));
			endcase
			n = (p < 5) ? 60 : 110;
			for (int i = 0; i < n && sent < TOTAL_ITEMS; i++) begin
				random_beat();
				// let the pipe empty once mid-phase
				if (p == 1 && i == 30) begin
					item_valid <= 0;
					while (sb.pending.size() != 0) @(posedge clk);
				end
			end
			drain();
		end

		$display("Checked %0d address beats over %0d register settings (zero and mirror padding).",
			sb.matched, configs_run + 1);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("** overlap_tile_padding_address_gen: PASSED **");
		else
			$display("** overlap_tile_padding_address_gen: FAILED **");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/otp_pkg.sv
hw/rtl/otp_cfg.sv
hw/rtl/otp_reflect_pipe.sv
hw/rtl/overlap_tile_padding_address_gen.sv
tb/tb_overlap_tile_padding_address_gen.sv
